/* hw/rtl/mbl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbl_pkg
// Shared types and constants of the multichannel biquad low-pass unit.
// ----------------------------------------------------------------------------
package mbl_pkg;

    // field widths
    localparam int CH_W     = 4;
    localparam int SMP_W    = 16;
    localparam int COEF_W   = 18;
    localparam int PROD_W   = COEF_W + SMP_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int FRAC_W   = 16;
    localparam int RND_W    = ACC_W - FRAC_W;

    // configuration port
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int REG_IW   = 3;

    localparam logic [REG_IW-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IW-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IW-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IW-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IW-1:0] REG_A2 = 3'd4;

    // coefficient reset values, signed Q1.16
    localparam logic signed [COEF_W-1:0] B0_RST = 18'sd1826;
    localparam logic signed [COEF_W-1:0] B1_RST = 18'sd3652;
    localparam logic signed [COEF_W-1:0] B2_RST = 18'sd1826;
    localparam logic signed [COEF_W-1:0] A1_RST = -18'sd96697;
    localparam logic signed [COEF_W-1:0] A2_RST = 18'sd38464;

    localparam logic signed [RND_W-1:0] SAT_MAX = 21'sd32767;
    localparam logic signed [RND_W-1:0] SAT_MIN = -21'sd32768;
    localparam logic signed [ACC_W-1:0] RND_HALF = 37'sd32768;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        t_smp            sample_in;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] channel_out;
        t_smp            sample_out;
    } t_out_item;

    // coefficient set handed from the register block to the datapath
    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coef_set;

    // one history word per channel
    typedef struct packed {
        t_smp x2;
        t_smp x1;
        t_smp y2;
        t_smp y1;
    } t_hist;

    localparam int HIST_W = $bits(t_hist);

endpackage : mbl_pkg
`default_nettype wire

/* hw/rtl/multichannel_biquad_lowpass_unit.sv */
`default_nettype none
// Throughput: one sample per cycle while no channel repeats within three transfers and
// the output is not stalled. A sample for a channel still in stage 1 or stage 2 waits
// until that channel's history is written back (history RAM loop).
// Reset: coefficients return to defaults and per-channel valid flags clear, so every
// channel's history reads as zero at once; no clearing pass, no idle time after reset.
// ----------------------------------------------------------------------------
// multichannel_biquad_lowpass_unit
// Time-shared direct-form-1 biquad low-pass over NUM_CHANNELS channels with
// per-channel history in a synchronous RAM (read, multiply, sum, write back).
// ----------------------------------------------------------------------------
module multichannel_biquad_lowpass_unit
    import mbl_pkg::*;
#(
    parameter int NUM_CHANNELS = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // sample input
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in,
    // filtered output
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_coef_set        coef;

    // pipeline control and payload
    logic             adv;
    logic             in_range;
    logic             hazard;
    logic             in_go;
    logic [CH_AW-1:0] in_addr;

    logic             r_s1_vld;
    logic [CH_AW-1:0] r_s1_ch;
    t_smp             r_s1_x0;
    logic             r_s1_hvld;

    logic             r_s2_vld;
    logic [CH_AW-1:0] r_s2_ch;
    t_smp             r_s2_x0;
    t_smp             r_s2_x1;
    t_smp             r_s2_y1;
    t_prod            r_s2_p0, r_s2_p1, r_s2_p2, r_s2_p3, r_s2_p4;

    logic             r_out_vld;
    t_out_item        r_out;

    logic [NUM_CHANNELS-1:0] r_hist_vld;

    logic [HIST_W-1:0] ram_rdata;
    t_hist             hist_rd;
    t_hist             hist_wr;
    logic              ram_we;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] biased;
    logic signed [RND_W-1:0] rnd;
    t_smp                    y0;

    // ------------------------------------------------------------------
    // configuration registers
    mbl_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_coef    (coef)
    );

    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // input acceptance: stall on output backpressure or same-channel hazard
    assign adv      = !r_out_vld || i_out_ready;
    assign in_range = 32'(i_in.channel) < NUM_CHANNELS;
    assign in_addr  = CH_AW'(i_in.channel);
    assign hazard   = in_range && ((r_s1_vld && (r_s1_ch == in_addr)) ||
                                   (r_s2_vld && (r_s2_ch == in_addr)));
    assign o_in_ready = adv && !hazard;
    // out-of-range channels are taken and dropped
    assign in_go    = i_in_valid && o_in_ready && in_range;

    // ------------------------------------------------------------------
    // history RAM: one word {x2, x1, y2, y1} per channel
    assign ram_we = adv && r_s2_vld;

    mbl_ram #(
        .WIDTH (HIST_W),
        .DEPTH (NUM_CHANNELS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_ch),
        .i_wdata (hist_wr),
        .i_re    (in_go),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // never-written entries read as zero
    assign hist_rd = r_s1_hvld ? t_hist'(ram_rdata) : '0;

    // ------------------------------------------------------------------
    // valid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_hist_vld <= '0;
        end else begin
            if (adv) begin
                r_s1_vld  <= in_go;
                r_s2_vld  <= r_s1_vld;
                r_out_vld <= r_s2_vld;
            end
            if (ram_we) begin
                r_hist_vld[r_s2_ch] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: capture sample; stage 2: five products
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ch   <= in_addr;
            r_s1_x0   <= i_in.sample_in;
            r_s1_hvld <= r_hist_vld[in_addr];

            r_s2_ch   <= r_s1_ch;
            r_s2_x0   <= r_s1_x0;
            r_s2_x1   <= hist_rd.x1;
            r_s2_y1   <= hist_rd.y1;
            r_s2_p0   <= coef.b0 * r_s1_x0;
            r_s2_p1   <= coef.b1 * hist_rd.x1;
            r_s2_p2   <= coef.b2 * hist_rd.x2;
            r_s2_p3   <= coef.a1 * hist_rd.y1;
            r_s2_p4   <= coef.a2 * hist_rd.y2;
        end
    end

    // ------------------------------------------------------------------
    // sum, round half up, saturate to Q7.8
    always_comb begin
        acc    = r_s2_p0 + r_s2_p1 + r_s2_p2 - r_s2_p3 - r_s2_p4;
        biased = acc + RND_HALF;
        rnd    = signed'(biased[ACC_W-1:FRAC_W]);
        if (rnd > SAT_MAX) begin
            y0 = SAT_MAX[SMP_W-1:0];
        end else if (rnd < SAT_MIN) begin
            y0 = SAT_MIN[SMP_W-1:0];
        end else begin
            y0 = rnd[SMP_W-1:0];
        end
    end

    // shifted history for write-back
    assign hist_wr.x1 = r_s2_x0;
    assign hist_wr.x2 = r_s2_x1;
    assign hist_wr.y1 = y0;
    assign hist_wr.y2 = r_s2_y1;

    // output register
    always_ff @(posedge i_clk) begin
        if (adv && r_s2_vld) begin
            r_out.channel_out <= CH_W'(r_s2_ch);
            r_out.sample_out  <= y0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // assertions
    a_no_rw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_go && ram_we) |-> (in_addr != r_s2_ch))
        else $error("history read and write-back hit the same channel");

    a_stages_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s2_vld) |-> (r_s1_ch != r_s2_ch))
        else $error("one channel in two pipeline stages");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_s1_vld) && $stable(r_s2_vld)))
        else $error("pipeline moved during output stall");

    a_s1_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (32'(r_s1_ch) < NUM_CHANNELS))
        else $error("out-of-range channel entered the pipeline");

endmodule : multichannel_biquad_lowpass_unit
`default_nettype wire

/* hw/rtl/mbl_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbl_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mbl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 12
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : mbl_ram
`default_nettype wire

/* hw/rtl/mbl_apb_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbl_apb_regs
// APB-style coefficient register file: five signed Q1.16 coefficients.
// ----------------------------------------------------------------------------
module mbl_apb_regs
    import mbl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [APB_AW-1:0] i_paddr,
    input  wire logic [APB_DW-1:0] i_pwdata,
    output logic      [APB_DW-1:0] o_prdata,
    output t_coef_set              o_coef
);

    t_coef_set         r_coef;
    logic              wr_xfer;
    logic [REG_IW-1:0] reg_idx;
    t_coef             wr_val;
    t_coef             rd_val;

    assign wr_xfer = i_psel && i_penable && i_pwrite;
    assign reg_idx = i_paddr[APB_AW-1:2];
    assign wr_val  = t_coef'(i_pwdata[COEF_W-1:0]);

    // register writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.b0 <= B0_RST;
            r_coef.b1 <= B1_RST;
            r_coef.b2 <= B2_RST;
            r_coef.a1 <= A1_RST;
            r_coef.a2 <= A2_RST;
        end else if (wr_xfer) begin
            case (reg_idx)
                REG_B0:  r_coef.b0 <= wr_val;
                REG_B1:  r_coef.b1 <= wr_val;
                REG_B2:  r_coef.b2 <= wr_val;
                REG_A1:  r_coef.a1 <= wr_val;
                REG_A2:  r_coef.a2 <= wr_val;
                default: ;
            endcase
        end
    end

    // read mux, sign-extended to the bus
    always_comb begin
        case (reg_idx)
            REG_B0:  rd_val = r_coef.b0;
            REG_B1:  rd_val = r_coef.b1;
            REG_B2:  rd_val = r_coef.b2;
            REG_A1:  rd_val = r_coef.a1;
            REG_A2:  rd_val = r_coef.a2;
            default: rd_val = '0;
        endcase
    end

    assign o_prdata = APB_DW'(rd_val);
    assign o_coef   = r_coef;

endmodule : mbl_apb_regs
`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multichannel biquad low-pass unit. A directed
// table and random sample streams go in over valid/ready, and between streams
// the APB port steps through several coefficient sets. A fixed-point biquad
// predictor, run on each accepted in-range transfer, supplies the expected samples.
// ----------------------------------------------------------------------------
module testbench;
    import mbl_pkg::*;

    localparam int NCH          = 12;
    localparam int SETTLE_CYC   = 6;      // output latency plus margin
    localparam int BURST_LEN    = 80;     // random samples per coefficient set
    localparam int HOLD_CYC     = 60;     // long receiver back-pressure stretch
    localparam int HOLD_AT      = 300;    // transfer count that triggers it
    localparam int MAX_REPORTS  = 10;

    // DUT inputs, all known from time zero
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    t_in_item            i_in        = '0;
    logic                i_out_ready = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [APB_AW-1:0]   paddr       = '0;
    logic [APB_DW-1:0]   pwdata      = '0;

    // DUT outputs
    logic                o_in_ready;
    logic                o_out_valid;
    t_out_item           o_out;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // filter shadow state
    t_coef     coefs [5];
    t_smp      hist_x1 [NCH];
    t_smp      hist_x2 [NCH];
    t_smp      hist_y1 [NCH];
    t_smp      hist_y2 [NCH];
    t_out_item filtered_q [$];

    int        samples_sent = 0;
    int        src_idle_pct = 8;
    int        snk_idle_pct = 69;
    int        mismatches   = 0;
    int        last_ch      = 0;
    bit        hold_done    = 1'b0;

    typedef struct {
        int ch;
        int smp;
        bit known;
        int want;
    } t_row;

    // directed rows; typed results only on channels with empty history
    t_row directed_rows [24] = '{
        '{0,   32767, 1'b1,  913},   // positive full scale, reset gains
        '{1,  -32768, 1'b1, -913},   // negative full scale, reset gains
        '{11,      0, 1'b1,    0},   // top channel, zero in
        '{2,       1, 1'b1,    0},   // one LSB rounds away
        '{2,      -1, 1'b0,    0},
        '{12,  32767, 1'b0,    0},   // out-of-range channels: dropped
        '{15, -32768, 1'b0,    0},
        '{0,   32767, 1'b0,    0},   // step response
        '{0,   32767, 1'b0,    0},
        '{0,   32767, 1'b0,    0},
        '{1,  -32768, 1'b0,    0},
        '{1,  -32768, 1'b0,    0},
        '{3,   32767, 1'b0,    0},   // back-to-back on one channel
        '{3,  -32768, 1'b0,    0},
        '{3,   32767, 1'b0,    0},
        '{13,  21845, 1'b0,    0},
        '{14, -21846, 1'b0,    0},
        '{4,   21845, 1'b0,    0},
        '{5,  -21846, 1'b0,    0},
        '{6,     255, 1'b0,    0},
        '{7,    -256, 1'b0,    0},
        '{8,    4096, 1'b0,    0},
        '{9,   -4097, 1'b0,    0},
        '{10,  32767, 1'b0,    0}
    };

    multichannel_biquad_lowpass_unit #(
        .NUM_CHANNELS (NCH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // direct-form-1 step: exact Q11.24 sum, round half up, saturate, shift history
    function automatic t_smp filter_sample(input int ch, input t_smp x0);
        longint acc;
        longint r;
        acc = longint'(coefs[REG_B0]) * longint'(x0)
            + longint'(coefs[REG_B1]) * longint'(hist_x1[ch])
            + longint'(coefs[REG_B2]) * longint'(hist_x2[ch])
            - longint'(coefs[REG_A1]) * longint'(hist_y1[ch])
            - longint'(coefs[REG_A2]) * longint'(hist_y2[ch]);
        r = (acc + 64'sd32768) >>> FRAC_W;
        if (r > longint'(SAT_MAX)) r = longint'(SAT_MAX);
        if (r < longint'(SAT_MIN)) r = longint'(SAT_MIN);
        hist_x2[ch] = hist_x1[ch];
        hist_x1[ch] = x0;
        hist_y2[ch] = hist_y1[ch];
        hist_y1[ch] = t_smp'(r[SMP_W-1:0]);
        return t_smp'(r[SMP_W-1:0]);
    endfunction

    // one input transfer; the expectation is queued at the accepting edge
    task automatic send_sample(input t_in_item it, input bit known, input int want);
        t_smp pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        samples_sent++;
        if (samples_sent < 140) begin
            src_idle_pct = 8;
            snk_idle_pct = 69;
        end else if (samples_sent < 280) begin
            src_idle_pct = 69;
            snk_idle_pct = 8;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        if (it.channel < NCH) begin
            pred = filter_sample(int'(it.channel), it.sample_in);
            filtered_q.push_back('{channel_out: it.channel,
                                   sample_out: known ? t_smp'(want) : pred});
        end
    endtask

    // APB write: setup then access, then back to idle; shadow follows the register rules
    task automatic apb_write(input logic [REG_IW-1:0] idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= REG_A2) coefs[idx] = t_coef'(data[COEF_W-1:0]);
        @(posedge i_clk);
    endtask

    // all five gains, with junk above the 18 coefficient bits
    task automatic load_gains(input t_coef b0, input t_coef b1, input t_coef b2,
                              input t_coef a1, input t_coef a2);
        apb_write(REG_B0, {14'($urandom), b0});
        apb_write(REG_B1, {14'($urandom), b1});
        apb_write(REG_B2, {14'($urandom), b2});
        apb_write(REG_A1, {14'($urandom), a1});
        apb_write(REG_A2, {14'($urandom), a2});
    endtask

    // let the pipe empty, dropped samples included
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic random_burst(input int count);
        t_in_item it;
        int       pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                it.channel = CH_W'($urandom_range(NCH, 2**CH_W - 1));
            else if (pick < 38)
                it.channel = CH_W'(last_ch);
            else
                it.channel = CH_W'($urandom_range(0, NCH - 1));
            if (it.channel < NCH) last_ch = int'(it.channel);
            pick = $urandom_range(0, 99);
            if (pick < 15)
                it.sample_in = 16'sh7FFF;
            else if (pick < 30)
                it.sample_in = t_smp'(16'h8000);
            else if (pick < 50)
                it.sample_in = t_smp'(int'($urandom_range(0, 1023)) - 512);
            else
                it.sample_in = t_smp'($urandom);
            send_sample(it, 1'b0, 0);
        end
    endtask

    // receiver: random stalls plus one long hold-off to back up the block
    initial begin
        forever begin
            @(posedge i_clk);
            if (!hold_done && samples_sent >= HOLD_AT) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
                hold_done = 1'b1;
            end
            i_out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // compare every output transfer with the oldest expectation
    always @(posedge i_clk) begin : check_output
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (filtered_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output: ch %0d sample %0d",
                             o_out.channel_out, o_out.sample_out);
            end else begin
                want = filtered_q.pop_front();
                if (o_out.channel_out !== want.channel_out ||
                    o_out.sample_out !== want.sample_out) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected ch %0d sample %0d, got ch %0d sample %0d",
                                 want.channel_out, want.sample_out,
                                 o_out.channel_out, o_out.sample_out);
                end
            end
        end
    end

    // main sequence
    initial begin
        t_in_item it;
        coefs = '{B0_RST, B1_RST, B2_RST, A1_RST, A2_RST};
        for (int c = 0; c < NCH; c++) begin
            hist_x1[c] = '0;
            hist_x2[c] = '0;
            hist_y1[c] = '0;
            hist_y2[c] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table with reset gains
        foreach (directed_rows[k]) begin
            it.channel   = CH_W'(directed_rows[k].ch);
            it.sample_in = t_smp'(directed_rows[k].smp);
            send_sample(it, directed_rows[k].known, directed_rows[k].want);
        end
        random_burst(BURST_LEN);
        drain_pipe();

        // largest positive gains: saturation on both rails
        load_gains(t_coef'(131071), t_coef'(131071), t_coef'(131071),
                   t_coef'(131071), t_coef'(131071));
        random_burst(BURST_LEN);
        drain_pipe();

        // most negative gains
        load_gains(t_coef'(-131072), t_coef'(-131072), t_coef'(-131072),
                   t_coef'(-131072), t_coef'(-131072));
        random_burst(BURST_LEN);
        drain_pipe();

        // random gains, then writes to unused indexes that must not stick
        load_gains(t_coef'($urandom), t_coef'($urandom), t_coef'($urandom),
                   t_coef'($urandom), t_coef'($urandom));
        for (int k = int'(REG_A2) + 1; k < 2**REG_IW; k++)
            apb_write(REG_IW'(k), $urandom);
        random_burst(BURST_LEN);
        drain_pipe();

        // back to the stock low-pass gains
        load_gains(B0_RST, B1_RST, B2_RST, A1_RST, A2_RST);
        random_burst(BURST_LEN);
        drain_pipe();

        if (mismatches == 0 && filtered_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mbl_pkg.sv
hw/rtl/mbl_ram.sv
hw/rtl/mbl_apb_regs.sv
hw/rtl/multichannel_biquad_lowpass_unit.sv
bench/testbench.sv
